### design/positional_list_engine_unit_macros.svh
// Assertion helpers for the list engine. Each expands to one labeled concurrent
// assertion clocked on clk and disabled while rst_n is low.
`ifndef POSITIONAL_LIST_ENGINE_UNIT_MACROS_SVH
`define POSITIONAL_LIST_ENGINE_UNIT_MACROS_SVH

// Same-cycle implication: whenever ante holds, cons holds too.
`define PLE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: whenever ante holds, cons holds in the next cycle.
`define PLE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/ple_pkg.sv
package ple_pkg;

  localparam int CAPACITY = 64;
  localparam int DATA_W   = 32;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int ACT_W    = 3;
  localparam int POS_W    = 7;
  localparam int LEN_W    = 7;
  localparam int STAT_W   = 2;
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

  // request codes
  localparam logic [ACT_W-1:0] ACT_INSERT = 3'd0;
  localparam logic [ACT_W-1:0] ACT_ERASE  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_READ   = 3'd2;
  localparam logic [ACT_W-1:0] ACT_POP    = 3'd3;
  localparam logic [ACT_W-1:0] ACT_COUNT  = 3'd4;
  localparam logic [ACT_W-1:0] ACT_DEDUP  = 3'd5;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_BAD_POS = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY   = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SHUP,
    S_SHDN,
    S_RDH,
    S_CNT,
    S_DRAIN,
    S_PUT,
    S_DD_RDI,
    S_DD_SCAN,
    S_RESP
  } state_t;

endpackage

### design/positional_list_engine_unit.sv
// Ordered list of up to 64 signed 32-bit entries held in one RAM with a
// registered read port and an independent write port; slot 0 is the head.
// One request beat in gives one result beat out. The engine takes a new request
// only while idle, but a finished result waits in the output register, so the
// next request is taken while the previous result is still stalled. Work per
// request: read-nth reads one slot; pop reads the head, then moves each entry
// behind it; erase moves each entry behind the removed one; insert moves each
// entry at or behind the index; count-matching reads every entry; and
// remove-duplicates walks each entry against the entries kept so far. Bad
// requests go straight to the response. Every cost is set by the single RAM
// read port, which moves one entry per cycle. Shifts read one slot and, in the
// next cycle, write the data read into its neighbouring slot, so a read and a
// write never hit the same slot in one cycle. Slots at or beyond the length are
// never read, so the RAM needs no clearing after reset.
module positional_list_engine_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [ple_pkg::ACT_W-1:0]          in_action,
  input  logic [ple_pkg::POS_W-1:0]          in_position,
  input  logic signed [ple_pkg::DATA_W-1:0]  in_value,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [ple_pkg::DATA_W-1:0]  out_result_value,
  output logic [ple_pkg::LEN_W-1:0]          out_match_count,
  output logic [ple_pkg::LEN_W-1:0]          out_length_now,
  output logic [ple_pkg::STAT_W-1:0]         out_status
);
  import ple_pkg::*;

  `include "positional_list_engine_unit_macros.svh"

  // control state
  state_t               state_r, state_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic                 wb_en_r, wb_en_nxt;    // shift write-back pending
  logic                 cap_r, cap_nxt;        // capture read data as result
  logic                 cmp_r, cmp_nxt;        // compare read data with value
  logic                 capi_r, capi_nxt;      // dedupe: read data is candidate
  logic                 ddc_r, ddc_nxt;        // dedupe: read data is kept entry
  logic                 out_valid_r, out_valid_nxt;

  // request payload and walk pointers
  logic [ACT_W-1:0]          act_r, act_nxt;
  logic [ADDR_W-1:0]         pos_r, pos_nxt;
  logic signed [DATA_W-1:0]  val_r, val_nxt;
  logic [ADDR_W-1:0]         ptr_r, ptr_nxt;
  logic [ADDR_W-1:0]         lim_r, lim_nxt;
  logic [ADDR_W-1:0]         wb_addr_r, wb_addr_nxt;
  logic [ADDR_W-1:0]         j_r, j_nxt;
  logic [CNT_W-1:0]          k_r, k_nxt;
  logic signed [DATA_W-1:0]  cand_r, cand_nxt;
  logic signed [DATA_W-1:0]  res_value_r, res_value_nxt;
  logic [CNT_W-1:0]          mcnt_r, mcnt_nxt;
  logic [STAT_W-1:0]         status_r, status_nxt;

  // output register
  logic signed [DATA_W-1:0]  out_value_r, out_value_nxt;
  logic [LEN_W-1:0]          out_mcnt_r, out_mcnt_nxt;
  logic [LEN_W-1:0]          out_len_r, out_len_nxt;
  logic [STAT_W-1:0]         out_status_r, out_status_nxt;

  // entry RAM
  logic signed [DATA_W-1:0]  mem [CAPACITY];
  logic                      rd_en;
  logic [ADDR_W-1:0]         rd_addr;
  logic signed [DATA_W-1:0]  rd_data_r;
  logic                      wr_en;
  logic [ADDR_W-1:0]         wr_addr;
  logic signed [DATA_W-1:0]  wr_data;

  // request decode
  logic                      accept;
  logic                      out_free;
  logic [CMP_W-1:0]          pos_c;
  logic [CMP_W-1:0]          cnt_c;
  state_t                    dec_state;
  logic [STAT_W-1:0]         dec_status;
  logic signed [DATA_W-1:0]  dec_res;
  logic [CNT_W-1:0]          dec_count;
  logic [ADDR_W-1:0]         dec_ptr;
  logic [ADDR_W-1:0]         dec_lim;

  // dedupe scan flags
  logic dd_issue;
  logic dd_seen;
  logic dd_keep;
  logic dd_last;

  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE);

  assign out_valid        = out_valid_r;
  assign out_result_value = out_value_r;
  assign out_match_count  = out_mcnt_r;
  assign out_length_now   = out_len_r;
  assign out_status       = out_status_r;

  assign pos_c = CMP_W'(in_position);
  assign cnt_c = CMP_W'(count_r);

  assign dd_issue = (CNT_W'(j_r) < k_r);
  assign dd_seen  = ddc_r && (rd_data_r == cand_r);
  assign dd_keep  = !capi_r && !ddc_r && !dd_issue;
  assign dd_last  = (ptr_r == lim_r);

  // Classify the request at the input: pick the first walk state, the status
  // and the new length, and drop straight to the response for bad requests.
  always_comb begin
    dec_state  = S_RESP;
    dec_status = ST_OK;
    dec_res    = '0;
    dec_count  = count_r;
    dec_ptr    = '0;
    dec_lim    = ADDR_W'(count_r - CNT_W'(1));
    case (in_action)
      ACT_INSERT: begin
        if (pos_c > cnt_c) begin
          dec_status = ST_BAD_POS;
        end else if (count_r == CNT_W'(CAPACITY)) begin
          dec_status = ST_FULL;
        end else begin
          dec_count = count_r + CNT_W'(1);
          dec_ptr   = ADDR_W'(count_r - CNT_W'(1));
          // appending at the tail needs no shift
          dec_state = (pos_c == cnt_c) ? S_PUT : S_SHUP;
        end
      end
      ACT_ERASE: begin
        if (pos_c >= cnt_c) begin
          dec_status = ST_BAD_POS;
        end else begin
          dec_count = count_r - CNT_W'(1);
          dec_ptr   = ADDR_W'(in_position) + ADDR_W'(1);
          // erasing the tail entry needs no shift
          dec_state = (pos_c == cnt_c - CMP_W'(1)) ? S_RESP : S_SHDN;
        end
      end
      ACT_READ: begin
        if (count_r == '0) begin
          dec_status = ST_EMPTY;
        end else if (pos_c > cnt_c) begin
          dec_status = ST_BAD_POS;
        end else begin
          dec_ptr   = (in_position == '0) ? '0 : ADDR_W'(in_position - POS_W'(1));
          dec_state = S_RDH;
        end
      end
      ACT_POP: begin
        if (count_r == '0) begin
          dec_status = ST_EMPTY;
          dec_res    = '1;
        end else begin
          dec_count = count_r - CNT_W'(1);
          dec_state = S_RDH;
        end
      end
      ACT_COUNT: begin
        if (count_r != '0) begin
          dec_state = S_CNT;
        end
      end
      ACT_DEDUP: begin
        // the head is always kept, so start the walk at slot 1
        if (count_r > CNT_W'(1)) begin
          dec_ptr   = ADDR_W'(1);
          dec_state = S_DD_RDI;
        end
      end
      default: begin
        dec_status = ST_BAD_POS;
      end
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:    state_nxt = accept ? dec_state : S_IDLE;
      S_SHUP:    state_nxt = (ptr_r == pos_r) ? S_DRAIN : S_SHUP;
      S_SHDN:    state_nxt = (ptr_r == lim_r) ? S_DRAIN : S_SHDN;
      S_RDH:     state_nxt = (act_r == ACT_POP && lim_r != '0) ? S_SHDN : S_DRAIN;
      S_CNT:     state_nxt = (ptr_r == lim_r) ? S_DRAIN : S_CNT;
      S_DRAIN:   state_nxt = (act_r == ACT_INSERT) ? S_PUT : S_RESP;
      S_PUT:     state_nxt = S_RESP;
      S_DD_RDI:  state_nxt = S_DD_SCAN;
      S_DD_SCAN: begin
        if (dd_seen || dd_keep) begin
          state_nxt = dd_last ? S_RESP : S_DD_RDI;
        end
      end
      S_RESP:    state_nxt = out_free ? S_IDLE : S_RESP;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // datapath, RAM controls and output register
  always_comb begin
    count_nxt      = count_r;
    wb_en_nxt      = 1'b0;
    cap_nxt        = 1'b0;
    cmp_nxt        = 1'b0;
    capi_nxt       = 1'b0;
    ddc_nxt        = 1'b0;
    act_nxt        = act_r;
    pos_nxt        = pos_r;
    val_nxt        = val_r;
    ptr_nxt        = ptr_r;
    lim_nxt        = lim_r;
    wb_addr_nxt    = wb_addr_r;
    j_nxt          = j_r;
    k_nxt          = k_r;
    cand_nxt       = cand_r;
    res_value_nxt  = res_value_r;
    mcnt_nxt       = mcnt_r;
    status_nxt     = status_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_value_nxt  = out_value_r;
    out_mcnt_nxt   = out_mcnt_r;
    out_len_nxt    = out_len_r;
    out_status_nxt = out_status_r;
    rd_en          = 1'b0;
    rd_addr        = '0;
    wr_en          = 1'b0;
    wr_addr        = '0;
    wr_data        = '0;

    // second half of the read pipeline: consume last cycle's read data
    if (wb_en_r) begin
      wr_en   = 1'b1;
      wr_addr = wb_addr_r;
      wr_data = rd_data_r;
    end
    if (cap_r) begin
      res_value_nxt = rd_data_r;
    end
    if (cmp_r && (rd_data_r == val_r)) begin
      mcnt_nxt = mcnt_r + CNT_W'(1);
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          act_nxt       = in_action;
          pos_nxt       = ADDR_W'(in_position);
          val_nxt       = in_value;
          count_nxt     = dec_count;
          ptr_nxt       = dec_ptr;
          lim_nxt       = dec_lim;
          k_nxt         = CNT_W'(1);
          res_value_nxt = dec_res;
          mcnt_nxt      = '0;
          status_nxt    = dec_status;
        end
      end
      S_SHUP: begin
        // walk from the tail down to the index, moving each entry up one slot
        rd_en       = 1'b1;
        rd_addr     = ptr_r;
        wb_en_nxt   = 1'b1;
        wb_addr_nxt = ptr_r + ADDR_W'(1);
        if (ptr_r != pos_r) begin
          ptr_nxt = ptr_r - ADDR_W'(1);
        end
      end
      S_SHDN: begin
        // walk toward the tail, moving each entry down one slot
        rd_en       = 1'b1;
        rd_addr     = ptr_r;
        wb_en_nxt   = 1'b1;
        wb_addr_nxt = ptr_r - ADDR_W'(1);
        if (ptr_r != lim_r) begin
          ptr_nxt = ptr_r + ADDR_W'(1);
        end
      end
      S_RDH: begin
        rd_en   = 1'b1;
        rd_addr = ptr_r;
        cap_nxt = 1'b1;
        ptr_nxt = ADDR_W'(1);
      end
      S_CNT: begin
        rd_en   = 1'b1;
        rd_addr = ptr_r;
        cmp_nxt = 1'b1;
        if (ptr_r != lim_r) begin
          ptr_nxt = ptr_r + ADDR_W'(1);
        end
      end
      S_DRAIN: begin
        // let the last read finish its write-back, capture or compare
      end
      S_PUT: begin
        wr_en   = 1'b1;
        wr_addr = pos_r;
        wr_data = val_r;
      end
      S_DD_RDI: begin
        rd_en    = 1'b1;
        rd_addr  = ptr_r;
        capi_nxt = 1'b1;
        j_nxt    = '0;
      end
      S_DD_SCAN: begin
        if (capi_r) begin
          cand_nxt = rd_data_r;
        end
        // stream the kept entries past the candidate; stop at the first match
        if (!dd_seen && dd_issue) begin
          rd_en   = 1'b1;
          rd_addr = j_r;
          ddc_nxt = 1'b1;
          j_nxt   = j_r + ADDR_W'(1);
        end
        if (dd_keep) begin
          wr_en   = 1'b1;
          wr_addr = k_r[ADDR_W-1:0];
          wr_data = cand_r;
          k_nxt   = k_r + CNT_W'(1);
        end
        if (dd_seen || dd_keep) begin
          if (dd_last) begin
            count_nxt = dd_keep ? (k_r + CNT_W'(1)) : k_r;
          end else begin
            ptr_nxt = ptr_r + ADDR_W'(1);
          end
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = res_value_r;
          out_mcnt_nxt   = LEN_W'(mcnt_r);
          out_len_nxt    = LEN_W'(count_r);
          out_status_nxt = status_r;
        end
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      wb_en_r     <= 1'b0;
      cap_r       <= 1'b0;
      cmp_r       <= 1'b0;
      capi_r      <= 1'b0;
      ddc_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      wb_en_r     <= wb_en_nxt;
      cap_r       <= cap_nxt;
      cmp_r       <= cmp_nxt;
      capi_r      <= capi_nxt;
      ddc_r       <= ddc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    act_r        <= act_nxt;
    pos_r        <= pos_nxt;
    val_r        <= val_nxt;
    ptr_r        <= ptr_nxt;
    lim_r        <= lim_nxt;
    wb_addr_r    <= wb_addr_nxt;
    j_r          <= j_nxt;
    k_r          <= k_nxt;
    cand_r       <= cand_nxt;
    res_value_r  <= res_value_nxt;
    mcnt_r       <= mcnt_nxt;
    status_r     <= status_nxt;
    out_value_r  <= out_value_nxt;
    out_mcnt_r   <= out_mcnt_nxt;
    out_len_r    <= out_len_nxt;
    out_status_r <= out_status_nxt;
  end

  // entry RAM: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  `PLE_ASSERT_IMP(a_len_cap, 1'b1, count_r <= CNT_W'(CAPACITY), "list length above capacity")
  `PLE_ASSERT_IMP(a_rw_slot, wr_en && rd_en, wr_addr != rd_addr, "read and write hit one slot")
  `PLE_ASSERT_NXT(a_busy, accept, state_r != S_IDLE, "accepted beat left engine idle")
  `PLE_ASSERT_NXT(a_len_hold, state_r != S_IDLE && state_r != S_DD_SCAN, $stable(count_r),
                  "length changed outside accept or dedupe end")

endmodule

### bench/positional_list_engine_unit_tb.sv
`timescale 1ns / 1ps

import ple_pkg::*;

typedef struct {
  logic signed [DATA_W-1:0] value;
  logic [LEN_W-1:0]         mcount;
  logic [LEN_W-1:0]         length;
  logic [STAT_W-1:0]        status;
} list_reply_t;

class list_scoreboard;
  logic signed [DATA_W-1:0] entries [CAPACITY];
  int unsigned              fill;
  list_reply_t              pending [$];
  int                       errors;

  function new();
    fill   = 0;
    errors = 0;
  endfunction

  task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    errors++;
  endtask

  // Apply one request beat to the list copy and queue the reply it causes.
  function void apply_request(logic [ACT_W-1:0] act, logic [POS_W-1:0] pos,
                              logic signed [DATA_W-1:0] val);
    list_reply_t r;
    int          i;
    int          j;
    int          kept;
    bit          seen;
    r.value  = '0;
    r.mcount = '0;
    r.status = ST_OK;
    case (act)
      ACT_INSERT: begin
        if (pos > fill) r.status = ST_BAD_POS;
        else if (fill >= CAPACITY) r.status = ST_FULL;
        else begin
          for (i = fill; i > pos; i--) entries[i] = entries[i-1];
          entries[pos] = val;
          fill++;
        end
      end
      ACT_ERASE: begin
        if (pos >= fill) r.status = ST_BAD_POS;
        else begin
          for (i = pos; i + 1 < fill; i++) entries[i] = entries[i+1];
          fill--;
        end
      end
      ACT_READ: begin
        if (fill == 0) r.status = ST_EMPTY;
        else if (pos > fill) r.status = ST_BAD_POS;
        else r.value = entries[(pos == 0) ? 0 : pos - 1];
      end
      ACT_POP: begin
        if (fill == 0) begin
          r.value  = -1;
          r.status = ST_EMPTY;
        end else begin
          r.value = entries[0];
          for (i = 0; i + 1 < fill; i++) entries[i] = entries[i+1];
          fill--;
        end
      end
      ACT_COUNT: begin
        for (i = 0; i < fill; i++)
          if (entries[i] == val) r.mcount++;
      end
      ACT_DEDUP: begin
        kept = 0;
        for (i = 0; i < fill; i++) begin
          seen = 1'b0;
          for (j = 0; j < kept; j++)
            if (entries[j] == entries[i]) seen = 1'b1;
          if (!seen) begin
            entries[kept] = entries[i];
            kept++;
          end
        end
        fill = kept;
      end
      default: r.status = ST_BAD_POS;
    endcase
    r.length = LEN_W'(fill);
    pending.push_back(r);
  endfunction

  task check_reply(logic signed [DATA_W-1:0] value, logic [LEN_W-1:0] mcount,
                   logic [LEN_W-1:0] length, logic [STAT_W-1:0] status);
    list_reply_t want;
    if (pending.size() == 0) begin
      report_mismatch("unexpected reply beat", {32'd0, value}, 64'd0);
    end else begin
      want = pending.pop_front();
      if (value !== want.value)   report_mismatch("result_value", value, want.value);
      if (mcount !== want.mcount) report_mismatch("match_count", mcount, want.mcount);
      if (length !== want.length) report_mismatch("length_now", length, want.length);
      if (status !== want.status) report_mismatch("status", status, want.status);
    end
  endtask
endclass

module positional_list_engine_unit_tb;

  // Action codes the block does not define; they must be rejected.
  localparam logic [ACT_W-1:0] ACT_RSVD_LO = 3'd6;
  localparam logic [ACT_W-1:0] ACT_RSVD_HI = 3'd7;

  localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;

  // Longest single request is a dedupe of a full list.
  localparam int DRAIN_CYCLES = 3000;
  localparam int CYCLE_LIMIT  = 20_000_000;
  localparam int PHASE_ITEMS  = 362;
  localparam int SEGMENT      = 60;

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  logic [ACT_W-1:0]         in_action;
  logic [POS_W-1:0]         in_position;
  logic signed [DATA_W-1:0] in_value;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [DATA_W-1:0] out_result_value;
  logic [LEN_W-1:0]         out_match_count;
  logic [LEN_W-1:0]         out_length_now;
  logic [STAT_W-1:0]        out_status;

  int unsigned    src_idle_pct  = 0;
  int unsigned    sink_stall_pct = 0;
  int unsigned    cycle_count   = 0;
  list_scoreboard sb;

  positional_list_engine_unit u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_action        (in_action),
    .in_position      (in_position),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_value (out_result_value),
    .out_match_count  (out_match_count),
    .out_length_now   (out_length_now),
    .out_status       (out_status)
  );

  always #1 clk = ~clk;

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Receiver side: throttle the result channel at the falling edge.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < sink_stall_pct);
  end

  // Observe both channels at the rising edge. Values read here are the ones
  // the block sees at this edge, since all drives happen at the falling edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall)
        sb.check_reply(out_result_value, out_match_count, out_length_now, out_status);
      if (in_valid && !in_stall)
        sb.apply_request(in_action, in_position, in_value);
    end
  end

  // Drive one request beat. Entered and left at a falling edge; holds the
  // payload until the block takes it.
  task send_request(logic [ACT_W-1:0] act, logic [POS_W-1:0] pos,
                    logic signed [DATA_W-1:0] val);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_action   <= act;
    in_position <= pos;
    in_value    <= val;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // A tiny pool 40 percent of the time so duplicates and matches are common; some extremes; else random.
  function automatic logic signed [DATA_W-1:0] pick_value();
    logic signed [DATA_W-1:0] v;
    int unsigned              r;
    r = $urandom_range(99);
    if (r < 40) begin
      v = $urandom_range(7);
      v = v - 3;
    end else if (r < 55) begin
      case ($urandom_range(3))
        0:       v = VAL_MIN;
        1:       v = VAL_MAX;
        2:       v = -1;
        default: v = '0;
      endcase
    end else begin
      v = $urandom;
    end
    return v;
  endfunction

  // Random traffic steered toward a moving target length, so the list spends
  // time empty, short, and pinned at capacity.
  task run_random(int n_items);
    int unsigned              target;
    int unsigned              len;
    int unsigned              r;
    logic [ACT_W-1:0]         act;
    logic [POS_W-1:0]         pos;
    logic signed [DATA_W-1:0] val;
    target = 0;
    for (int idx = 0; idx < n_items; idx++) begin
      if (idx % SEGMENT == 0)
        target = ((idx / SEGMENT) % 4 == 1) ? CAPACITY : $urandom_range(24);
      len = sb.fill;
      pos = POS_W'($urandom_range(127));
      val = pick_value();
      r   = $urandom_range(99);
      if (r < ((len < target) ? 55 : 12)) begin
        act = ACT_INSERT;
        if ($urandom_range(9) != 0) pos = POS_W'($urandom_range(len));
        else                        pos = POS_W'($urandom_range(127, len + 1));
      end else begin
        r = $urandom_range(99);
        if (r < 24) begin
          act = ACT_ERASE;
          if (len > 0 && $urandom_range(9) != 0) pos = POS_W'($urandom_range(len - 1));
          else                                   pos = POS_W'($urandom_range(127, len));
        end else if (r < 52) begin
          act = ACT_READ;
          if ($urandom_range(9) != 0) pos = POS_W'($urandom_range(len));
          else                        pos = POS_W'($urandom_range(127, len + 1));
        end else if (r < 68) begin
          act = ACT_POP;
        end else if (r < 88) begin
          act = ACT_COUNT;
          // aim at a stored value half the time so matches show up
          if (len > 0 && $urandom_range(1)) val = sb.entries[$urandom_range(len - 1)];
        end else if (r < 94) begin
          act = ACT_DEDUP;
        end else begin
          act = $urandom_range(1) ? ACT_RSVD_HI : ACT_RSVD_LO;
        end
      end
      send_request(act, pos, val);
    end
  endtask

  initial begin
    sb          = new();
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_action   = ACT_INSERT;
    in_position = '0;
    in_value    = '0;

    // Hold reset low from the start, then release it at a falling edge.
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: corner cases on an empty list first.
    send_request(ACT_POP,     7'd0,   32'sd0);
    send_request(ACT_READ,    7'd0,   32'sd0);
    send_request(ACT_ERASE,   7'd0,   32'sd0);
    send_request(ACT_INSERT,  7'd1,   32'sd5);
    send_request(ACT_COUNT,   7'd0,   32'sd0);
    send_request(ACT_DEDUP,   7'd0,   32'sd0);
    send_request(ACT_RSVD_LO, 7'd0,   32'sd0);
    send_request(ACT_RSVD_HI, 7'd127, -32'sd1);
    // Build a short list with extreme values, then probe it.
    send_request(ACT_INSERT,  7'd0,   VAL_MAX);
    send_request(ACT_INSERT,  7'd1,   VAL_MIN);
    send_request(ACT_INSERT,  7'd1,   -32'sd1);
    send_request(ACT_INSERT,  7'd3,   32'sd0);
    send_request(ACT_INSERT,  7'd5,   32'sd9);
    send_request(ACT_READ,    7'd0,   32'sd0);
    send_request(ACT_READ,    7'd4,   32'sd0);
    send_request(ACT_READ,    7'd5,   32'sd0);
    send_request(ACT_READ,    7'd127, 32'sd0);
    send_request(ACT_INSERT,  7'd0,   VAL_MIN);
    send_request(ACT_COUNT,   7'd0,   VAL_MIN);
    send_request(ACT_DEDUP,   7'd0,   32'sd0);
    send_request(ACT_ERASE,   7'd4,   32'sd0);
    send_request(ACT_ERASE,   7'd3,   32'sd0);
    send_request(ACT_POP,     7'd0,   32'sd0);

    // Random phases: no idling, idle sender, stalling receiver, both light.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1:       begin src_idle_pct = 88; sink_stall_pct = 0;  end
        2:       begin src_idle_pct = 0;  sink_stall_pct = 88; end
        default: begin src_idle_pct = 17; sink_stall_pct = 17; end
      endcase
      run_random(PHASE_ITEMS);
    end
    in_valid <= 1'b0;

    // Drain outstanding replies, then watch for strays.
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
